// File: rtl/csvfs_pkg.sv
// Shared types and constants for the CSV field splitter.
package csvfs_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] SEPARATOR_RESET    = 8'd44;
  localparam logic [BYTE_W-1:0] FIRST_QUOTE_RESET  = 8'd34;
  localparam logic [BYTE_W-1:0] SECOND_QUOTE_RESET = 8'd39;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEPARATOR    = 2'd0,
    REG_FIRST_QUOTE  = 2'd1,
    REG_SECOND_QUOTE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] separator_char;
    logic [BYTE_W-1:0] first_quote_char;
    logic [BYTE_W-1:0] second_quote_char;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              field_end;
    logic              record_end;
  } result_t;

endpackage

// File: rtl/csvfs_byte_if.sv
// Input channel: one raw record byte per beat.
interface csvfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       record_last;

  modport source (output valid, output in_byte, output record_last, input ready);
  modport sink   (input valid, input in_byte, input record_last, output ready);
endinterface

// File: rtl/csvfs_result_if.sv
// Output channel: one decoded result per beat.
interface csvfs_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field_end;
  logic       record_end;

  modport source (output valid, output out_byte, output byte_valid, output field_end,
                  output record_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input field_end,
                  input record_end, output ready);
endinterface

// File: rtl/csvfs_cfg.sv
// Configuration registers: separator and the two quote bytes.
module csvfs_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [csvfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csvfs_pkg::BYTE_W-1:0]       cfg_data,
  output csvfs_pkg::cfg_t                    cfg
);
  import csvfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator_char    <= SEPARATOR_RESET;
      cfg.first_quote_char  <= FIRST_QUOTE_RESET;
      cfg.second_quote_char <= SECOND_QUOTE_RESET;
    end else if (cfg_we) begin
      // Indexes past the last register are dropped.
      if (cfg_index == REG_SEPARATOR) begin
        cfg.separator_char <= cfg_data;
      end
      if (cfg_index == REG_FIRST_QUOTE) begin
        cfg.first_quote_char <= cfg_data;
      end
      if (cfg_index == REG_SECOND_QUOTE) begin
        cfg.second_quote_char <= cfg_data;
      end
    end
  end

endmodule

// File: rtl/csvfs_decode.sv
// Input register, quote state and the per-byte decode logic.
module csvfs_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  csvfs_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csvfs_pkg::BYTE_W-1:0]  in_byte,
  input  logic                          record_last,
  input  logic                          out_free,
  output logic                          res_load,
  output csvfs_pkg::result_t            res
);
  import csvfs_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;

  logic              in_quote;
  logic              in_quote_next;
  logic [BYTE_W-1:0] active_quote;
  logic [BYTE_W-1:0] active_quote_next;
  logic              quote_pending;
  logic              quote_pending_next;

  logic              outside;
  logic              has_result;
  logic              advance;

  always_comb begin
    in_quote_next      = in_quote;
    active_quote_next  = active_quote;
    quote_pending_next = quote_pending;
    outside            = 1'b1;
    res.out_byte       = '0;
    res.byte_valid     = 1'b0;
    res.field_end      = 1'b0;
    res.record_end     = s1_last;

    if (in_quote) begin
      outside = 1'b0;
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (s1_byte == active_quote) begin
          res.out_byte   = s1_byte;
          res.byte_valid = 1'b1;
        end else begin
          // A lone quote closed the run; this byte is handled as unquoted.
          in_quote_next     = 1'b0;
          active_quote_next = '0;
          outside           = 1'b1;
        end
      end else if (s1_byte == active_quote) begin
        quote_pending_next = 1'b1;
      end else begin
        res.out_byte   = s1_byte;
        res.byte_valid = 1'b1;
      end
    end

    if (outside) begin
      if (s1_byte == cfg.first_quote_char || s1_byte == cfg.second_quote_char) begin
        in_quote_next      = 1'b1;
        active_quote_next  = s1_byte;
        quote_pending_next = 1'b0;
      end else if (s1_byte == cfg.separator_char) begin
        res.field_end = 1'b1;
      end else begin
        res.out_byte   = s1_byte;
        res.byte_valid = 1'b1;
      end
    end

    if (s1_last) begin
      in_quote_next      = 1'b0;
      active_quote_next  = '0;
      quote_pending_next = 1'b0;
    end
  end

  assign has_result = res.byte_valid | res.field_end | res.record_end;
  // A swallowed quote leaves the stage without needing the output register.
  assign advance    = s1_valid & (out_free | ~has_result);
  assign res_load   = advance & has_result;
  assign in_ready   = ~s1_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
      s1_last <= record_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote      <= 1'b0;
      active_quote  <= '0;
      quote_pending <= 1'b0;
    end else if (advance) begin
      in_quote      <= in_quote_next;
      active_quote  <= active_quote_next;
      quote_pending <= quote_pending_next;
    end
  end

  a_pending_needs_run: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> in_quote)
    else $error("quote pending outside a quoted run");

  a_closed_run_no_quote: assert property (@(posedge clk) disable iff (rst)
    !in_quote |-> active_quote == '0)
    else $error("active quote kept after the run closed");

  a_record_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> !in_quote && !quote_pending)
    else $error("quote state survived a record end");

endmodule

// File: rtl/csvfs_out_reg.sv
// Output register that holds one result until the receiver takes it.
module csvfs_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_load,
  input  csvfs_pkg::result_t  res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output csvfs_pkg::result_t  out_res
);
  import csvfs_pkg::*;

  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  a_result_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.byte_valid || out_res.field_end || out_res.record_end))
    else $error("empty result presented");

  a_byte_zero_when_unused: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.byte_valid |-> out_res.out_byte == '0)
    else $error("stray data byte on a result without one");

endmodule

// File: rtl/csv_field_splitter_unit.sv
// Top level of the CSV field splitter.
//
// din carries one raw byte of a record per beat, with record_last on the
// final byte. dout carries the decoded results: a field byte (byte_valid),
// the end of a field closed by a separator (field_end) and the end of the
// record (record_end), which may come alone or with either of the others.
// An opening or pending quote byte makes no result unless it ends the
// record. Quotes that open or close a run are removed, and doubled quotes
// inside a run give one literal quote. The cfg port writes the separator
// (index 0) and the two quote bytes (indexes 1 and 2); other indexes are
// ignored. The user must write them while the block is idle; the block
// itself does not enforce this. A result passes the input register, then
// the output register. The block takes one byte per cycle unless dout
// stalls; the decode and quote-state update between the two registers
// are combinational. Reset clears both pipeline registers and the quote
// state and restores the default comma, double quote and single quote.
// When dout stalls, the output register holds its result and the input
// register keeps its byte, so din.ready falls only once both are occupied.
module csv_field_splitter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [csvfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csvfs_pkg::BYTE_W-1:0]    cfg_data,
  csvfs_byte_if.sink                      din,
  csvfs_result_if.source                  dout
);
  import csvfs_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_load;
  logic    out_free;

  csvfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csvfs_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (din.valid),
    .in_ready    (din.ready),
    .in_byte     (din.in_byte),
    .record_last (din.record_last),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  csvfs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_res   (out_res)
  );

  assign dout.out_byte   = out_res.out_byte;
  assign dout.byte_valid = out_res.byte_valid;
  assign dout.field_end  = out_res.field_end;
  assign dout.record_end = out_res.record_end;

endmodule

// File: tb/sv/csv_field_splitter_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for csv_field_splitter_unit: directed table, then random CSV records.
module csv_field_splitter_unit_test;
  import csvfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [7:0] COMMA  = 8'h2C;
  localparam logic [7:0] DQUOTE = 8'h22;
  localparam logic [7:0] SQUOTE = 8'h27;

  localparam int unsigned PHASE_BEATS   = 230;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 100;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
    bit         typed;
    bit         emits;
    result_t    want;
  } directed_row_t;

  // Rows marked typed carry their result; the rest go through the predictor.
  localparam directed_row_t DIRECTED [24] = '{
    '{8'h00,  1'b0, 1'b1, 1'b1, '{8'h00,  1'b1, 1'b0, 1'b0}},
    '{8'hFF,  1'b0, 1'b1, 1'b1, '{8'hFF,  1'b1, 1'b0, 1'b0}},
    '{COMMA,  1'b0, 1'b1, 1'b1, '{8'h00,  1'b0, 1'b1, 1'b0}},
    '{DQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{COMMA,  1'b0, 1'b1, 1'b1, '{COMMA,  1'b1, 1'b0, 1'b0}},
    '{DQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{DQUOTE, 1'b0, 1'b1, 1'b1, '{DQUOTE, 1'b1, 1'b0, 1'b0}},
    '{SQUOTE, 1'b0, 1'b1, 1'b1, '{SQUOTE, 1'b1, 1'b0, 1'b0}},
    '{DQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{8'h61,  1'b0, 1'b0, 1'b0, '0},
    '{COMMA,  1'b1, 1'b1, 1'b1, '{8'h00,  1'b0, 1'b1, 1'b1}},
    '{SQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{DQUOTE, 1'b0, 1'b1, 1'b1, '{DQUOTE, 1'b1, 1'b0, 1'b0}},
    '{SQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{SQUOTE, 1'b1, 1'b1, 1'b1, '{SQUOTE, 1'b1, 1'b0, 1'b1}},
    '{DQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{8'h78,  1'b1, 1'b1, 1'b1, '{8'h78,  1'b1, 1'b0, 1'b1}},
    '{DQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{DQUOTE, 1'b1, 1'b1, 1'b1, '{8'h00,  1'b0, 1'b0, 1'b1}},
    '{DQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{DQUOTE, 1'b0, 1'b1, 1'b0, '0},
    '{COMMA,  1'b0, 1'b0, 1'b0, '0},
    '{DQUOTE, 1'b1, 1'b1, 1'b1, '{8'h00,  1'b0, 1'b0, 1'b1}},
    '{8'h80,  1'b1, 1'b0, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  csvfs_byte_if   din_ch ();
  csvfs_result_if dout_ch ();

  csv_field_splitter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch)
  );

  // Predictor state: characters and quote tracking as the splitter should hold them.
  logic [7:0] sep_char    = COMMA;
  logic [7:0] quote_a     = DQUOTE;
  logic [7:0] quote_b     = SQUOTE;
  bit         quoted      = 1'b0;
  logic [7:0] open_quote  = 8'h00;
  bit         quote_held  = 1'b0;

  result_t     decoded_due [$];
  int unsigned beats_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_calm        = 0;
  int unsigned rx_calm        = 0;
  bit          rx_hold        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Returns 1 if the byte produces a result, updating the quote state.
  function automatic bit split_byte(input logic [7:0] b, input logic last, output result_t r);
    bit         outside;
    bit         valid;
    bit         fend;
    logic [7:0] ob;
    outside = 1'b1;
    valid   = 1'b0;
    fend    = 1'b0;
    ob      = 8'h00;
    if (quoted) begin
      outside = 1'b0;
      if (quote_held) begin
        quote_held = 1'b0;
        if (b == open_quote) begin
          ob    = b;
          valid = 1'b1;
        end else begin
          // A lone quote closed the run; this byte is handled outside quotes.
          quoted     = 1'b0;
          open_quote = 8'h00;
          outside    = 1'b1;
        end
      end else if (b == open_quote) begin
        quote_held = 1'b1;
      end else begin
        ob    = b;
        valid = 1'b1;
      end
    end
    if (outside) begin
      if (b == quote_a || b == quote_b) begin
        quoted     = 1'b1;
        open_quote = b;
        quote_held = 1'b0;
      end else if (b == sep_char) begin
        fend = 1'b1;
      end else begin
        ob    = b;
        valid = 1'b1;
      end
    end
    if (last) begin
      quoted     = 1'b0;
      open_quote = 8'h00;
      quote_held = 1'b0;
    end
    r.out_byte   = valid ? ob : 8'h00;
    r.byte_valid = valid;
    r.field_end  = fend;
    r.record_end = last;
    return valid || fend || last;
  endfunction

  // Mostly no pause, sometimes a short one, rarely a long one; calm stretches have none.
  function automatic int unsigned pick_pause(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == sep_char || b == quote_a || b == quote_b);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0: return sep_char;
      1: return quote_a;
      2: return quote_b;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Offers one byte and waits for its beat; the result it owes is queued on acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit fixed = 1'b0,
                           input bit fixed_emits = 1'b0, input result_t fixed_want = '0);
    int unsigned gap;
    result_t     predicted;
    bit          emits;
    gap = rx_hold ? 0 : pick_pause(tx_calm);
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid       <= 1'b1;
    din_ch.in_byte     <= b;
    din_ch.record_last <= last;
    do @(posedge clk);
    while (!din_ch.ready);
    emits = split_byte(b, last, predicted);
    if (fixed) begin
      emits     = fixed_emits;
      predicted = fixed_want;
    end
    if (emits) decoded_due.push_back(predicted);
    beats_sent++;
  endtask

  task automatic send_record();
    logic [7:0]  rec [$];
    logic [7:0]  q;
    int unsigned nfields;
    int unsigned len;
    int unsigned kind;
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = $urandom_range(0, 5);
        repeat (len) rec.push_back(plain_byte());
      end else if (kind < 8) begin
        q = $urandom_range(0, 1) ? quote_a : quote_b;
        rec.push_back(q);
        len = $urandom_range(0, 5);
        repeat (len) begin
          case ($urandom_range(0, 5))
            0: rec.push_back(sep_char);
            1: begin
              rec.push_back(q);
              rec.push_back(q);
            end
            2: rec.push_back(q == quote_a ? quote_b : quote_a);
            default: rec.push_back(plain_byte());
          endcase
        end
        // Now and then the run is left open to the end of the record.
        if ($urandom_range(0, 9) != 0) rec.push_back(q);
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) rec.push_back(noise_byte());
      end
      if (f != nfields - 1) rec.push_back(sep_char);
    end
    if (rec.size() == 0) rec.push_back(plain_byte());
    foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
  endtask

  task automatic run_phase();
    int unsigned start;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) send_record();
  endtask

  // Registers change only with the pipeline empty.
  task automatic settle();
    din_ch.valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_chars(input logic [7:0] s, input logic [7:0] q1, input logic [7:0] q2,
                            input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SEPARATOR;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_FIRST_QUOTE;
    cfg_data  <= q1;
    @(posedge clk);
    cfg_index <= REG_SECOND_QUOTE;
    cfg_data  <= q2;
    @(posedge clk);
    // The spare index must not touch any register.
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= ~s;
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    sep_char = s;
    quote_a  = q1;
    quote_b  = q2;
  endtask

  initial begin
    din_ch.valid       <= 1'b0;
    din_ch.in_byte     <= 8'h00;
    din_ch.record_last <= 1'b0;
    dout_ch.ready      <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_byte(DIRECTED[i].in_byte, DIRECTED[i].last, DIRECTED[i].typed,
                DIRECTED[i].emits, DIRECTED[i].want);
    end

    run_phase();
    settle();
    load_chars(8'h00, 8'hFF, 8'hFF, 1'b0);
    run_phase();
    settle();
    load_chars(8'hFF, 8'h00, 8'h7C, 1'b1);
    run_phase();
    settle();
    load_chars(DQUOTE, DQUOTE, SQUOTE, 1'b0);
    run_phase();
    settle();
    load_chars(8'h09, SQUOTE, DQUOTE, 1'b0);
    run_phase();
    settle();
    load_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'b1);
    run_phase();
    settle();
    load_chars(COMMA, DQUOTE, SQUOTE, 1'b0);
    run_phase();

    din_ch.valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: checks each beat against the oldest expectation and drives ready.
  initial begin
    int unsigned stall_left;
    int unsigned g;
    result_t     got;
    result_t     want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) begin
        got.out_byte   = dout_ch.out_byte;
        got.byte_valid = dout_ch.byte_valid;
        got.field_end  = dout_ch.field_end;
        got.record_end = dout_ch.record_end;
        if (decoded_due.size() == 0) begin
          note_mismatch($sformatf("result %0d unexpected: byte %02h v%b f%b r%b", results_seen,
                                  got.out_byte, got.byte_valid, got.field_end, got.record_end));
        end else begin
          want = decoded_due.pop_front();
          if (got.out_byte !== want.out_byte)
            note_mismatch($sformatf("result %0d out_byte %02h, expected %02h", results_seen,
                                    got.out_byte, want.out_byte));
          if (got.byte_valid !== want.byte_valid)
            note_mismatch($sformatf("result %0d byte_valid %b, expected %b", results_seen,
                                    got.byte_valid, want.byte_valid));
          if (got.field_end !== want.field_end)
            note_mismatch($sformatf("result %0d field_end %b, expected %b", results_seen,
                                    got.field_end, want.field_end));
          if (got.record_end !== want.record_end)
            note_mismatch($sformatf("result %0d record_end %b, expected %b", results_seen,
                                    got.record_end, want.record_end));
        end
        results_seen++;
      end
      if (rx_hold) begin
        dout_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        dout_ch.ready <= 1'b0;
      end else begin
        g = pick_pause(rx_calm);
        dout_ch.ready <= (g == 0);
        if (g > 0) stall_left = g - 1;
      end
    end
  end

  // Long back-pressure: the result side stops while bytes keep coming, so the input stalls.
  initial begin
    wait (beats_sent >= 500);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
    wait (beats_sent >= 1200);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/csvfs_pkg.sv
rtl/csvfs_byte_if.sv
rtl/csvfs_result_if.sv
rtl/csvfs_cfg.sv
rtl/csvfs_decode.sv
rtl/csvfs_out_reg.sv
rtl/csv_field_splitter_unit.sv
tb/sv/csv_field_splitter_unit_test.sv
